@@ hw/rtl/touch_contact_slot_table_top_macros.svh @@
// ----------------------------------------------------------------------------
// Touch contact slot table assertion macros
// Shared concurrent assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef TOUCH_CONTACT_SLOT_TABLE_TOP_MACROS_SVH
`define TOUCH_CONTACT_SLOT_TABLE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCST_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TCST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/tcst_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch contact slot table package
// Field widths, action and status codes, and controller/datapath interface
// structures.
// ----------------------------------------------------------------------------
package tcst_pkg;

    localparam int ID_W       = 16;
    localparam int POS_W      = 16;
    localparam int RANK_W     = 8;
    localparam int ACT_W      = 3;
    localparam int STATUS_W   = 2;
    localparam int CNT_OUT_W  = 4;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 88;

    localparam logic [ACT_W-1:0] ACT_DOWN   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_MOVE   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_UP     = 3'd2;
    localparam logic [ACT_W-1:0] ACT_CANCEL = 3'd3;
    localparam logic [ACT_W-1:0] ACT_KILL   = 3'd4;
    localparam logic [ACT_W-1:0] ACT_ORIGIN = 3'd5;
    localparam logic [ACT_W-1:0] ACT_QUERY  = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd3;

    typedef struct packed {
        logic load;
        logic find_step;
        logic apply;
        logic query_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic last;
    } t_stat;

endpackage

@@ hw/rtl/tcst_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch contact slot table controller
// Sequences lookup scan, update, query scan and result hand-off, and owns the
// input ready and output valid handshake signals.
// ----------------------------------------------------------------------------
module tcst_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output tcst_pkg::t_cmd o_cmd,
    input  tcst_pkg::t_stat i_stat
);
    import tcst_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_APPLY,
        S_QUERY,
        S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    t_cmd   w_cmd;

    always_comb begin
        w_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load = 1'b1;
                    n_state    = S_FIND;
                end
            end
            S_FIND: begin
                w_cmd.find_step = 1'b1;
                if (i_stat.last) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                w_cmd.apply = 1'b1;
                n_state     = S_QUERY;
            end
            S_QUERY: begin
                w_cmd.query_step = 1'b1;
                if (i_stat.last) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = w_cmd;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

@@ hw/rtl/tcst_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch contact slot table datapath
// Slot storage, serial id lookup, single-slot or clear-all update and serial rank
// query with the output result register.
// ----------------------------------------------------------------------------
module tcst_dp #(
    parameter int SLOTS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  tcst_pkg::t_cmd                   i_cmd,
    output tcst_pkg::t_stat                  o_stat,
    input  logic [tcst_pkg::IN_DATA_W-1:0]   i_in_data,
    input  logic [tcst_pkg::ACT_W-1:0]       i_in_user,
    output logic [tcst_pkg::OUT_DATA_W-1:0]  o_out_data
);
    import tcst_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    logic [SLOTS-1:0]        r_valid;
    logic [ID_W-1:0]         r_slot_id      [SLOTS];
    logic signed [POS_W-1:0] r_slot_cur_x   [SLOTS];
    logic signed [POS_W-1:0] r_slot_cur_y   [SLOTS];
    logic signed [POS_W-1:0] r_slot_start_x [SLOTS];
    logic signed [POS_W-1:0] r_slot_start_y [SLOTS];

    logic [ACT_W-1:0]        r_action;
    logic [ID_W-1:0]         r_id;
    logic signed [POS_W-1:0] r_px;
    logic signed [POS_W-1:0] r_py;
    logic [RANK_W-1:0]       r_rank;

    logic [IW-1:0]           r_idx;
    logic                    r_hit_found;
    logic [IW-1:0]           r_hit_idx;
    logic                    r_free_found;
    logic [IW-1:0]           r_free_idx;

    logic [STATUS_W-1:0]     r_status;
    logic [CW-1:0]           r_count;
    logic                    r_found;
    logic [ID_W-1:0]         r_q_id;
    logic signed [POS_W-1:0] r_q_x;
    logic signed [POS_W-1:0] r_q_y;
    logic signed [POS_W-1:0] r_q_sx;
    logic signed [POS_W-1:0] r_q_sy;

    logic [OUT_DATA_W-1:0]   r_out_data;
    logic                    w_last;
    logic                    w_origin;

    assign w_last   = (r_idx == LAST_IDX);
    assign w_origin = (r_action == ACT_ORIGIN);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_in_user;
            r_id     <= i_in_data[15:0];
            r_px     <= i_in_data[31:16];
            r_py     <= i_in_data[47:32];
            r_rank   <= i_in_data[55:48];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load || ((i_cmd.find_step || i_cmd.query_step) && w_last)) begin
            r_idx <= '0;
        end else if (i_cmd.find_step || i_cmd.query_step) begin
            r_idx <= r_idx + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_hit_found  <= 1'b0;
            r_free_found <= 1'b0;
        end else if (i_cmd.find_step) begin
            if (r_valid[r_idx] && (r_slot_id[r_idx] == r_id) && !r_hit_found) begin
                r_hit_found <= 1'b1;
                r_hit_idx   <= r_idx;
            end
            if (!r_valid[r_idx] && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.apply) begin
            case (r_action)
                ACT_DOWN: begin
                    if (!r_hit_found && r_free_found) begin
                        r_valid[r_free_idx] <= 1'b1;
                    end
                end
                ACT_UP, ACT_CANCEL: begin
                    if (r_hit_found) begin
                        r_valid[r_hit_idx] <= 1'b0;
                    end
                end
                ACT_KILL: begin
                    r_valid <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            case (r_action)
                ACT_DOWN: begin
                    if (!r_hit_found && r_free_found) begin
                        r_slot_id[r_free_idx]      <= r_id;
                        r_slot_cur_x[r_free_idx]   <= r_px;
                        r_slot_cur_y[r_free_idx]   <= r_py;
                        r_slot_start_x[r_free_idx] <= r_px;
                        r_slot_start_y[r_free_idx] <= r_py;
                    end
                end
                ACT_MOVE: begin
                    if (r_hit_found) begin
                        r_slot_cur_x[r_hit_idx] <= r_px;
                        r_slot_cur_y[r_hit_idx] <= r_py;
                    end
                end
                default: begin
                end
            endcase
        end else if (i_cmd.query_step && w_origin && r_valid[r_idx]) begin
            r_slot_start_x[r_idx] <= r_slot_cur_x[r_idx];
            r_slot_start_y[r_idx] <= r_slot_cur_y[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            case (r_action)
                ACT_DOWN: begin
                    if (r_hit_found) begin
                        r_status <= ST_DUP;
                    end else if (!r_free_found) begin
                        r_status <= ST_FULL;
                    end else begin
                        r_status <= ST_OK;
                    end
                end
                ACT_MOVE, ACT_UP, ACT_CANCEL: begin
                    r_status <= r_hit_found ? ST_OK : ST_UNKNOWN;
                end
                default: begin
                    r_status <= ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            r_count <= '0;
            r_found <= 1'b0;
            r_q_id  <= '0;
            r_q_x   <= '0;
            r_q_y   <= '0;
            r_q_sx  <= '0;
            r_q_sy  <= '0;
        end else if (i_cmd.query_step && r_valid[r_idx]) begin
            r_count <= r_count + CW'(1);
            if (RANK_W'(r_count) == r_rank) begin
                r_found <= 1'b1;
                r_q_id  <= r_slot_id[r_idx];
                r_q_x   <= r_slot_cur_x[r_idx];
                r_q_y   <= r_slot_cur_y[r_idx];
                r_q_sx  <= w_origin ? r_slot_cur_x[r_idx] : r_slot_start_x[r_idx];
                r_q_sy  <= w_origin ? r_slot_cur_y[r_idx] : r_slot_start_y[r_idx];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= {1'b0, r_q_sy, r_q_sx, r_q_y, r_q_x, r_q_id, r_found,
                           CNT_OUT_W'(r_count), r_status};
        end
    end

    assign o_stat.last = w_last;
    assign o_out_data  = r_out_data;

endmodule

@@ hw/rtl/touch_contact_slot_table_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch contact slot table
// Table of touch contacts keyed by contact id with down, move, up, cancel,
// kill, reset-origin and query events, one result per event.
// ----------------------------------------------------------------------------
//  Channel  Direction  Transaction contents
//  s_axis   in         tuser: action; tdata: touch_id, pos_x, pos_y, query_rank
//  m_axis   out        tdata: status, touch_count, query_found, query_id,
//                      query_x, query_y, start_x, start_y
//
// From acceptance to a valid result, each event runs an id and free-slot scan over
// every slot, one update step, a rank query scan over every slot and one output
// load; a new event is not accepted until the previous result has been loaded.
// Reset clears the slot valid bits at once; there is no clearing pass.
// A new event is accepted while a result waits in the output register, and a
// stalled output holds the controller in its hand-off state.
// ----------------------------------------------------------------------------
`include "touch_contact_slot_table_top_macros.svh"

module touch_contact_slot_table_top #(
    parameter int SLOTS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // touch_id[15:0], pos_x[31:16], pos_y[47:32], query_rank[55:48]
    input  logic [tcst_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // action[2:0]
    input  logic [tcst_pkg::ACT_W-1:0]      i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // status[1:0], touch_count[5:2], query_found[6], query_id[22:7],
    // query_x[38:23], query_y[54:39], start_x[70:55], start_y[86:71]
    output logic [tcst_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);
    import tcst_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    tcst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    tcst_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_in_data  (i_s_axis_tdata),
        .i_in_user  (i_s_axis_tuser),
        .o_out_data (o_m_axis_tdata)
    );

    `TCST_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready, "input ready after an accepted transaction")
    `TCST_ASSERT_IMPLY(a_load_when_free, i_clk, i_rst_n, w_cmd.out_load, !o_m_axis_tvalid || i_m_axis_tready, "output register overwritten before taken")
    `TCST_ASSERT_NEXT(a_valid_after_load, i_clk, i_rst_n, w_cmd.out_load, o_m_axis_tvalid, "result loaded without output valid")
    `TCST_ASSERT_IMPLY(a_no_overlap, i_clk, i_rst_n, w_cmd.find_step, !w_cmd.query_step && !w_cmd.apply, "lookup scan overlaps update or query")

endmodule
